// File: rtl/psdl_pkg.sv
package psdl_pkg;

  // Store geometry. Every address width and wrap constant follows from the depth.
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Fixed field widths.
  localparam int SAMPLE_W  = 16;
  localparam int DELAY_W   = 12;
  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Q1.15 unity.
  localparam int Q_ONE = 32768;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY = 2'd0,
    CFG_GAIN  = 2'd1,
    CFG_PAN   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_ACCUM,
    S_READ
  } state_e;

endpackage

// File: rtl/psdl_if.sv
interface psdl_sample_if;
  import psdl_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface psdl_result_if;
  import psdl_pkg::*;
  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface psdl_cfg_if;
  import psdl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/psdl_ram.sv
module psdl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/panned_sample_delay_line.sv
// Path: an accepted sample passes S_ACCUM, S_READ and the gain, pan and output registers.
// Each sample takes two read-modify-write passes on the store RAM (accumulate into the
// write slot, then read and clear the read slot); the next one can be accepted in S_READ.
// Reset: rst_ni resets the control registers at once, then a clearing sweep writes zero into all
// STORE_DEPTH slots, one per cycle; no sample is taken during the sweep.
// Configuration writes are taken at any time, including during the sweep.
module panned_sample_delay_line (
  input  logic           clk_i,
  input  logic           rst_ni,
  psdl_cfg_if.sink       cfg_i,
  psdl_sample_if.sink    smp_i,
  psdl_result_if.source  res_o
);
  import psdl_pkg::*;

  // Width wide enough to compare a delay register against the store depth.
  localparam int CMP_W = ((ADDR_W > DELAY_W) ? ADDR_W : DELAY_W) + 1;

  // Round a Q1.15 product to nearest (halves toward plus infinity) and saturate.
  function automatic sample_t round_sat(input logic signed [33:0] x);
    logic signed [33:0] y;
    y = (x + 34'sd16384) >>> 15;
    if (y > 34'sd32767) begin
      round_sat = 16'sh7fff;
    end else if (y < -34'sd32768) begin
      round_sat = 16'sh8000;
    end else begin
      round_sat = y[SAMPLE_W-1:0];
    end
  endfunction

  // Wrap an address that is known to stay below twice the depth.
  function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W:0] a);
    if (a >= (ADDR_W+1)'(STORE_DEPTH)) begin
      wrap_addr = ADDR_W'(a - (ADDR_W+1)'(STORE_DEPTH));
    end else begin
      wrap_addr = a[ADDR_W-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers. The port never stalls; unknown indexes are ignored.
  // ---------------------------------------------------------------------------
  logic [DELAY_W-1:0] delay_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [GAIN_W-1:0]  pan_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
      gain_q  <= GAIN_W'(Q_ONE);
      pan_q   <= GAIN_W'(Q_ONE / 2);
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_DELAY) begin
        delay_q <= cfg_i.data[DELAY_W-1:0];
      end else if (cfg_i.index == CFG_GAIN) begin
        gain_q <= cfg_i.data[GAIN_W-1:0];
      end else if (cfg_i.index == CFG_PAN) begin
        pan_q <= cfg_i.data[GAIN_W-1:0];
      end
    end
  end

  // Clamped views of the registers.
  logic [ADDR_W-1:0] dly_cl;
  logic [GAIN_W-1:0] gain_cl;
  logic [GAIN_W-1:0] pan_cl;
  logic [GAIN_W-1:0] pan_left;

  always_comb begin
    if (CMP_W'(delay_q) > CMP_W'(STORE_DEPTH - 1)) begin
      dly_cl = ADDR_W'(STORE_DEPTH - 1);
    end else begin
      dly_cl = ADDR_W'(delay_q);
    end
    gain_cl  = (gain_q > GAIN_W'(Q_ONE)) ? GAIN_W'(Q_ONE) : gain_q;
    pan_cl   = (pan_q > GAIN_W'(Q_ONE)) ? GAIN_W'(Q_ONE) : pan_q;
    pan_left = GAIN_W'(Q_ONE) - pan_cl;
  end

  // ---------------------------------------------------------------------------
  // Store RAM and the sequencer around it.
  // ---------------------------------------------------------------------------
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  sample_t           ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  sample_t           ram_rdata;

  psdl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] sweep_q, sweep_d;
  logic [ADDR_W-1:0] rp_q, rp_d;
  logic [1:0]        cnt_q, cnt_d;     // transactions accepted but not yet delivered

  // Per-item front-end registers.
  sample_t           smp_q;
  logic [ADDR_W-1:0] wp_q;
  logic              zero_dly_q;       // write slot equals read slot
  logic              fwd_zero_q;       // write slot is the slot being cleared right now
  sample_t           sum_q;

  logic              in_fire;
  logic              out_fire;
  logic              push;             // read value enters the scaling pipeline
  logic [ADDR_W-1:0] rp_next;
  logic [ADDR_W-1:0] item_rp;
  logic [ADDR_W-1:0] wp_new;
  logic signed [SAMPLE_W:0] acc_sum;
  sample_t           acc_old;
  sample_t           acc_sat;
  sample_t           rd_val;

  assign rp_next = (rp_q == ADDR_W'(STORE_DEPTH - 1)) ? '0 : rp_q + 1'b1;

  // While the previous item finishes its read pass, the new item's read slot is one ahead.
  assign item_rp = (state_q == S_READ) ? rp_next : rp_q;
  assign wp_new  = wrap_addr({1'b0, item_rp} + {1'b0, dly_cl});

  assign smp_i.ready = ((state_q == S_IDLE) || (state_q == S_READ)) && (cnt_q != 2'd3);
  assign in_fire     = smp_i.valid && smp_i.ready;
  assign out_fire    = res_o.valid && res_o.ready;

  // Accumulate with saturation. If the write slot is being cleared in the same cycle
  // its old contents were read, the cleared value is forwarded as zero.
  assign acc_old = fwd_zero_q ? '0 : ram_rdata;
  assign acc_sum = (SAMPLE_W+1)'(acc_old) + (SAMPLE_W+1)'(smp_q);

  always_comb begin
    if (acc_sum > (SAMPLE_W+1)'(32767)) begin
      acc_sat = 16'sh7fff;
    end else if (acc_sum < -(SAMPLE_W+1)'(32768)) begin
      acc_sat = 16'sh8000;
    end else begin
      acc_sat = acc_sum[SAMPLE_W-1:0];
    end
  end

  // With zero delay the slot just written is the slot read; take the sum directly.
  assign rd_val = zero_dly_q ? sum_q : ram_rdata;

  always_comb begin
    state_d   = state_q;
    sweep_d   = sweep_q;
    rp_d      = rp_q;
    ram_we    = 1'b0;
    ram_waddr = wp_q;
    ram_wdata = acc_sat;
    ram_raddr = wp_new;
    push      = 1'b0;
    unique case (state_q)
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = '0;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == ADDR_W'(STORE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_ACCUM;
        end
      end
      S_ACCUM: begin
        ram_we    = 1'b1;
        ram_waddr = wp_q;
        ram_wdata = acc_sat;
        ram_raddr = rp_q;
        state_d   = S_READ;
      end
      S_READ: begin
        ram_we    = 1'b1;
        ram_waddr = rp_q;
        ram_wdata = '0;
        push      = 1'b1;
        rp_d      = rp_next;
        state_d   = in_fire ? S_ACCUM : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (in_fire && !out_fire) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!in_fire && out_fire) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      sweep_q <= '0;
      rp_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      rp_q    <= rp_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      smp_q      <= smp_i.sample_in;
      wp_q       <= wp_new;
      zero_dly_q <= (dly_cl == '0);
      fwd_zero_q <= (state_q == S_READ) && (wp_new == rp_q);
    end
    if (state_q == S_ACCUM) begin
      sum_q <= acc_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Scaling pipeline: gain product, pan products, rounded output register.
  // The transaction count keeps at most two items here while one is in the
  // front end, so a push always finds the first stage free or moving.
  // ---------------------------------------------------------------------------
  logic               p1_v_q, p2_v_q, out_v_q;
  logic signed [32:0] p1_q;
  logic signed [32:0] pl_q, pr_q;
  sample_t            left_q, right_q;
  sample_t            scaled;
  logic               adv_out, adv_p2, adv_p1;

  assign adv_out = !out_v_q || res_o.ready;
  assign adv_p2  = !p2_v_q || adv_out;
  assign adv_p1  = !p1_v_q || adv_p2;

  assign scaled = round_sat(34'(p1_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv_p1) begin
        p1_v_q <= push;
      end
      if (adv_p2) begin
        p2_v_q <= p1_v_q;
      end
      if (adv_out) begin
        out_v_q <= p2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_p1 && push) begin
      p1_q <= 33'(rd_val) * signed'(33'(gain_cl));
    end
    if (adv_p2 && p1_v_q) begin
      pl_q <= 33'(scaled) * signed'(33'(pan_left));
      pr_q <= 33'(scaled) * signed'(33'(pan_cl));
    end
    if (adv_out && p2_v_q) begin
      left_q  <= round_sat(34'(pl_q));
      right_q <= round_sat(34'(pr_q));
    end
  end

  assign res_o.valid     = out_v_q;
  assign res_o.left_out  = left_q;
  assign res_o.right_out = right_q;

endmodule
